/* rtl/rpbf_pkg.sv */
// package: widths, register codes and polynomial coefficients of the pressure bump unit
`timescale 1ns / 1ps
package rpbf_pkg;

    localparam int RPBF_INDEX_BITS = 12;

    localparam int CFG_W   = 32;          // apb data width
    localparam int ADDR_W  = 5;           // eight registers at 4-byte steps
    localparam int SP_W    = 31;          // grid spacing
    localparam int RAD_W   = 31;          // radius
    localparam int OFFS_W  = 16;          // tile offsets
    localparam int SQ_IN_W = 64;          // radicand padded to whole digit pairs
    localparam int ROOT_W  = SQ_IN_W / 2;
    localparam int S_FRAC  = 30;          // s in q1.30
    localparam int S_W     = S_FRAC + 1;
    localparam int V_W     = 46;          // horner accumulator, signed
    localparam int LO_W    = 15;          // low split of the horner multiply
    localparam int POLY_STEPS = 6;        // five horner steps and the final s^6 step
    localparam int P_W     = 32;          // pressure

    localparam longint S_ONE = 64'sd1 <<< S_FRAC;

    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RADIUS,
        REG_PEAK,
        REG_SPACING_X,
        REG_SPACING_Y,
        REG_COL_OFFSET,
        REG_ROW_OFFSET
    } reg_idx_t;

    // start value of the horner chain, 252 in q.30
    localparam logic signed [V_W-1:0] POLY_INIT = V_W'(64'sd252 * S_ONE);

    // constant added after each step, in q.30; the last step adds one
    function automatic logic signed [V_W-1:0] poly_coef(input int k);
        logic signed [63:0] c;
        begin
            case (k)
                0:       c = -64'sd1386;
                1:       c =  64'sd3080;
                2:       c = -64'sd3465;
                3:       c =  64'sd1980;
                4:       c = -64'sd462;
                default: c =  64'sd1;
            endcase
            return V_W'(c * S_ONE);
        end
    endfunction

endpackage

/* rtl/rpbf_if.sv */
// stream interfaces: grid point in, pressure result out
`timescale 1ns / 1ps
interface rpbf_point_if
    import rpbf_pkg::*;
#(
    parameter int INDEX_BITS = RPBF_INDEX_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] column;
    logic [INDEX_BITS-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

interface rpbf_result_if
    import rpbf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [P_W-1:0] pressure;
    logic                  inside_res;

    modport source (output valid, output pressure, output inside_res, input ready);
    modport sink   (input valid, input pressure, input inside_res, output ready);
endinterface

/* rtl/radial_pressure_bump_field_unit.sv */
// top level: radial pressure bump, smoothstep order 5 falloff, fully pipelined
`timescale 1ns / 1ps
// usage
// - point channel (valid/ready): local column and row of one grid point per transfer
// - result channel (valid/ready): q16.16 pressure, saturated, and the inside flag
// - apb port: eight 32-bit registers at byte address 4*index, pready tied high;
//   write them only while no point is in flight
// - pipeline: 5 setup stages, 32 square-root stages, 31 divide stages, 12 polynomial
//   stages, clamp, peak multiply, saturate, output register
// - throughput: one point per cycle while the skid register is not full, set by one
//   root bit and one quotient bit per pipeline stage
// - stall: the whole pipeline freezes only when the output register and the
//   skid register both hold a result; until then points keep flowing while a
//   result waits, and nothing is lost or repeated
// - reset: all valid bits clear, registers return to centre 0, radius 1.0,
//   peak 0, spacing 0, offsets 0
module radial_pressure_bump_field_unit
    import rpbf_pkg::*;
#(
    parameter int INDEX_BITS = RPBF_INDEX_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    rpbf_point_if.sink        point,
    rpbf_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam int GI_W = ((INDEX_BITS > OFFS_W) ? INDEX_BITS : OFFS_W) + 1;
    localparam int X_W  = SP_W + GI_W;       // scaled coordinate
    localparam int D_W  = X_W + 1;           // signed distance
    localparam int SQ_W = 2 * RAD_W;         // one square
    localparam int D2_W = SQ_W + 1;          // sum of squares
    localparam int DIV_STAGES = S_FRAC + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [CFG_W-1:0]  center_x_reg, center_y_reg, peak_reg;
    logic [RAD_W-1:0]         radius_reg;
    logic [SP_W-1:0]          spacing_x_reg, spacing_y_reg;
    logic [OFFS_W-1:0]        col_off_reg, row_off_reg;
    logic [SQ_W-1:0]          rsq_reg;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_reg    <= RAD_W'(64'd65536);
            peak_reg      <= '0;
            spacing_x_reg <= '0;
            spacing_y_reg <= '0;
            col_off_reg   <= '0;
            row_off_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CENTER_X:   center_x_reg  <= pwdata;
                REG_CENTER_Y:   center_y_reg  <= pwdata;
                REG_RADIUS:     radius_reg    <= pwdata[RAD_W-1:0];
                REG_PEAK:       peak_reg      <= pwdata;
                REG_SPACING_X:  spacing_x_reg <= pwdata[SP_W-1:0];
                REG_SPACING_Y:  spacing_y_reg <= pwdata[SP_W-1:0];
                REG_COL_OFFSET: col_off_reg   <= pwdata[OFFS_W-1:0];
                REG_ROW_OFFSET: row_off_reg   <= pwdata[OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_CENTER_X:   prdata = center_x_reg;
            REG_CENTER_Y:   prdata = center_y_reg;
            REG_RADIUS:     prdata = CFG_W'(radius_reg);
            REG_PEAK:       prdata = peak_reg;
            REG_SPACING_X:  prdata = CFG_W'(spacing_x_reg);
            REG_SPACING_Y:  prdata = CFG_W'(spacing_y_reg);
            REG_COL_OFFSET: prdata = CFG_W'(col_off_reg);
            REG_ROW_OFFSET: prdata = CFG_W'(row_off_reg);
            default:        prdata = '0;
        endcase
    end

    // squared radius follows the radius register in the next cycle
    always_ff @(posedge clk)
    begin
        rsq_reg <= SQ_W'(radius_reg) * SQ_W'(radius_reg);
    end

    // ------------------------------------------------------------------
    // pipeline enable: everything moves unless the skid register is full
    // ------------------------------------------------------------------
    logic en;
    logic skid_full_reg;

    assign en          = !skid_full_reg;
    assign point.ready = en;

    // stage a: global indices
    logic            a_valid_reg;
    logic [GI_W-1:0] a_gi_reg, a_gj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_gi_reg <= GI_W'(point.column) + GI_W'(col_off_reg);
            a_gj_reg <= GI_W'(point.row) + GI_W'(row_off_reg);
        end
    end

    // stage b: scale by grid spacing
    logic           b_valid_reg;
    logic [X_W-1:0] b_x_reg, b_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x_reg <= X_W'(spacing_x_reg) * X_W'(a_gi_reg);
            b_y_reg <= X_W'(spacing_y_reg) * X_W'(a_gj_reg);
        end
    end

    // stage c: offset from the centre, magnitude
    logic                  c_valid_reg;
    logic [D_W-1:0]        c_ax_reg, c_ay_reg;
    logic signed [D_W-1:0] dx, dy;

    assign dx = signed'({1'b0, b_x_reg}) - D_W'(center_x_reg);
    assign dy = signed'({1'b0, b_y_reg}) - D_W'(center_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_ax_reg <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
            c_ay_reg <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
        end
    end

    // stage d: box test and squares (squares only meaningful inside the box)
    logic            d_valid_reg, d_ok_reg;
    logic [SQ_W-1:0] d_ax2_reg, d_ay2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_ok_reg  <= (c_ax_reg <= D_W'(radius_reg)) && (c_ay_reg <= D_W'(radius_reg));
            d_ax2_reg <= SQ_W'(c_ax_reg[RAD_W-1:0]) * SQ_W'(c_ax_reg[RAD_W-1:0]);
            d_ay2_reg <= SQ_W'(c_ay_reg[RAD_W-1:0]) * SQ_W'(c_ay_reg[RAD_W-1:0]);
        end
    end

    // stage e: squared distance and circle test
    logic            e_valid_reg, e_inside_reg;
    logic [D2_W-1:0] e_d2_reg;
    logic [D2_W-1:0] d2_sum;

    assign d2_sum = D2_W'(d_ax2_reg) + D2_W'(d_ay2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (en)
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_inside_reg <= d_ok_reg && (d2_sum <= D2_W'(rsq_reg));
            e_d2_reg     <= d2_sum;
        end
    end

    // ------------------------------------------------------------------
    // square root: one root bit per stage, radicand shifted two bits a stage
    // ------------------------------------------------------------------
    logic                 sq_valid_reg  [ROOT_W];
    logic                 sq_inside_reg [ROOT_W];
    logic [SQ_IN_W-1:0]   sq_n_reg      [ROOT_W];
    logic [ROOT_W-1:0]    sq_root_reg   [ROOT_W];
    logic [ROOT_W+1:0]    sq_rem_reg    [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        logic               in_valid, in_inside, ge;
        logic [SQ_IN_W-1:0] in_n;
        logic [ROOT_W-1:0]  in_root;
        logic [ROOT_W+1:0]  in_rem;
        logic [ROOT_W+3:0]  cur, trial;

        if (k == 0)
        begin : g_first
            assign in_valid  = e_valid_reg;
            assign in_inside = e_inside_reg;
            assign in_n      = SQ_IN_W'(e_d2_reg);
            assign in_root   = '0;
            assign in_rem    = '0;
        end
        else
        begin : g_next
            assign in_valid  = sq_valid_reg[k-1];
            assign in_inside = sq_inside_reg[k-1];
            assign in_n      = sq_n_reg[k-1];
            assign in_root   = sq_root_reg[k-1];
            assign in_rem    = sq_rem_reg[k-1];
        end

        assign cur   = {in_rem, in_n[SQ_IN_W-1 -: 2]};
        assign trial = (ROOT_W+4)'({in_root, 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k] <= 1'b0;
            else if (en)
                sq_valid_reg[k] <= in_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_inside_reg[k] <= in_inside;
                sq_n_reg[k]      <= in_n << 2;
                sq_root_reg[k]   <= {in_root[ROOT_W-2:0], ge};
                sq_rem_reg[k]    <= ge ? (ROOT_W+2)'(cur - trial) : (ROOT_W+2)'(cur);
            end
        end
    end

    // ------------------------------------------------------------------
    // s = r * 2^30 / radius: one quotient bit per stage (only a point outside the circle has r above radius)
    // ------------------------------------------------------------------
    logic              dv_valid_reg  [DIV_STAGES];
    logic              dv_inside_reg [DIV_STAGES];
    logic [ROOT_W-1:0] dv_rem_reg    [DIV_STAGES];
    logic [S_W-1:0]    dv_q_reg      [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic              in_valid, in_inside, ge;
        logic [ROOT_W-1:0] in_rem;
        logic [S_W-1:0]    in_q;
        logic [ROOT_W:0]   cur;

        if (k == 0)
        begin : g_first
            assign in_valid  = sq_valid_reg[ROOT_W-1];
            assign in_inside = sq_inside_reg[ROOT_W-1];
            assign in_q      = '0;
            assign in_rem    = '0;
            assign cur       = (ROOT_W+1)'(sq_root_reg[ROOT_W-1]);
        end
        else
        begin : g_next
            assign in_valid  = dv_valid_reg[k-1];
            assign in_inside = dv_inside_reg[k-1];
            assign in_q      = dv_q_reg[k-1];
            assign in_rem    = dv_rem_reg[k-1];
            assign cur       = {in_rem, 1'b0};
        end

        assign ge = cur >= (ROOT_W+1)'(radius_reg);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k] <= 1'b0;
            else if (en)
                dv_valid_reg[k] <= in_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_inside_reg[k] <= in_inside;
                dv_q_reg[k]      <= {in_q[S_W-2:0], ge};
                dv_rem_reg[k]    <= ge ? ROOT_W'(cur - (ROOT_W+1)'(radius_reg))
                                       : ROOT_W'(cur);
            end
        end
    end

    // zero radius: only the centre is inside, there s counts as zero; s above one is clamped to one
    logic [S_W-1:0] s_val;

    always_comb
    begin
        if (radius_reg == '0)
            s_val = '0;
        else if (dv_q_reg[DIV_STAGES-1] > S_W'(S_ONE))
            s_val = S_W'(S_ONE);
        else
            s_val = dv_q_reg[DIV_STAGES-1];
    end

    // ------------------------------------------------------------------
    // polynomial: each step is v = c + v*m/2^30 with the magnitude truncated,
    // split into two partial products then summed in the next stage;
    // s^2, s^3 and s^6 are built alongside in the first three steps
    // ------------------------------------------------------------------
    localparam int PHI_W = (V_W - LO_W) + S_W;
    localparam int PLO_W = LO_W + S_W;
    localparam int SS_W  = 2 * S_W;

    logic                  pa_valid_reg  [POLY_STEPS];
    logic                  pa_inside_reg [POLY_STEPS];
    logic                  pa_neg_reg    [POLY_STEPS];
    logic [S_W-1:0]        pa_s_reg      [POLY_STEPS];
    logic [S_W-1:0]        pa_sp_reg     [POLY_STEPS];
    logic [PHI_W-1:0]      pa_phi_reg    [POLY_STEPS];
    logic [PLO_W-1:0]      pa_plo_reg    [POLY_STEPS];
    logic                  pb_valid_reg  [POLY_STEPS];
    logic                  pb_inside_reg [POLY_STEPS];
    logic [S_W-1:0]        pb_s_reg      [POLY_STEPS];
    logic [S_W-1:0]        pb_sp_reg     [POLY_STEPS];
    logic signed [V_W-1:0] pb_v_reg      [POLY_STEPS];

    for (genvar k = 0; k < POLY_STEPS; k++)
    begin : g_poly
        logic                  in_valid, in_inside;
        logic [S_W-1:0]        in_s, in_sp, m, sp_next;
        logic signed [V_W-1:0] in_v;
        logic [V_W-1:0]        v_mag;
        logic [SS_W-1:0]       sp_prod;
        logic [PHI_W:0]        p_sum;
        logic [V_W-1:0]        p;

        if (k == 0)
        begin : g_first
            assign in_valid  = dv_valid_reg[DIV_STAGES-1];
            assign in_inside = dv_inside_reg[DIV_STAGES-1];
            assign in_s      = s_val;
            assign in_sp     = s_val;
            assign in_v      = POLY_INIT;
        end
        else
        begin : g_next
            assign in_valid  = pb_valid_reg[k-1];
            assign in_inside = pb_inside_reg[k-1];
            assign in_s      = pb_s_reg[k-1];
            assign in_sp     = pb_sp_reg[k-1];
            assign in_v      = pb_v_reg[k-1];
        end

        // last step multiplies by s^6, the others by s
        if (k == POLY_STEPS - 1)
        begin : g_m6
            assign m = in_sp;
        end
        else
        begin : g_ms
            assign m = in_s;
        end

        // power chain: s^2, then s^3, then s^6, then held
        if (k == 0)
        begin : g_sq
            assign sp_prod = SS_W'(in_s) * SS_W'(in_s);
        end
        else if (k == 1)
        begin : g_cube
            assign sp_prod = SS_W'(in_sp) * SS_W'(in_s);
        end
        else if (k == 2)
        begin : g_six
            assign sp_prod = SS_W'(in_sp) * SS_W'(in_sp);
        end
        else
        begin : g_hold
            assign sp_prod = SS_W'(in_sp) << S_FRAC;
        end

        assign sp_next = sp_prod[S_FRAC +: S_W];
        assign v_mag   = in_v[V_W-1] ? V_W'(-in_v) : V_W'(in_v);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pa_valid_reg[k] <= 1'b0;
                pb_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                pa_valid_reg[k] <= in_valid;
                pb_valid_reg[k] <= pa_valid_reg[k];
            end
        end

        // partial products
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_inside_reg[k] <= in_inside;
                pa_neg_reg[k]    <= in_v[V_W-1];
                pa_s_reg[k]      <= in_s;
                pa_sp_reg[k]     <= sp_next;
                pa_phi_reg[k]    <= PHI_W'(v_mag[V_W-1:LO_W]) * PHI_W'(m);
                pa_plo_reg[k]    <= PLO_W'(v_mag[LO_W-1:0]) * PLO_W'(m);
            end
        end

        assign p_sum = (PHI_W+1)'(pa_phi_reg[k]) + (PHI_W+1)'(pa_plo_reg[k] >> LO_W);
        assign p     = V_W'(p_sum >> (S_FRAC - LO_W));

        // sum, sign and coefficient
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pb_inside_reg[k] <= pa_inside_reg[k];
                pb_s_reg[k]      <= pa_s_reg[k];
                pb_sp_reg[k]     <= pa_sp_reg[k];
                pb_v_reg[k]      <= poly_coef(k) +
                                    (pa_neg_reg[k] ? -signed'(p) : signed'(p));
            end
        end
    end

    // ------------------------------------------------------------------
    // stage h: clamp g to [0, 1]
    // ------------------------------------------------------------------
    logic                  h_valid_reg, h_inside_reg;
    logic [S_W-1:0]        h_g_reg;
    logic signed [V_W-1:0] g_raw;

    assign g_raw = pb_v_reg[POLY_STEPS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (en)
            h_valid_reg <= pb_valid_reg[POLY_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_inside_reg <= pb_inside_reg[POLY_STEPS-1];
            if (g_raw < 0)
                h_g_reg <= '0;
            else if (g_raw > V_W'(S_ONE))
                h_g_reg <= S_W'(S_ONE);
            else
                h_g_reg <= S_W'(g_raw);
        end
    end

    // stage i: peak times g
    localparam int PM_W = P_W + 1;
    localparam int PK_W = P_W + S_W;

    logic            i_valid_reg, i_inside_reg, i_neg_reg;
    logic [PM_W-1:0] i_pm_reg;
    logic [P_W-1:0]  peak_mag;
    logic [PK_W-1:0] peak_prod;

    assign peak_mag  = peak_reg[P_W-1] ? P_W'(-peak_reg) : P_W'(peak_reg);
    assign peak_prod = PK_W'(peak_mag) * PK_W'(h_g_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_valid_reg <= 1'b0;
        else if (en)
            i_valid_reg <= h_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_inside_reg <= h_inside_reg;
            i_neg_reg    <= peak_reg[P_W-1];
            i_pm_reg     <= PM_W'(peak_prod >> S_FRAC);
        end
    end

    // stage j: sign, saturation, zero outside the radius
    localparam logic [PM_W-1:0] POS_MAX = PM_W'({1'b0, {(P_W-1){1'b1}}});
    localparam logic [PM_W-1:0] NEG_MAG = PM_W'({1'b1, {(P_W-1){1'b0}}});

    logic                  j_valid_reg, j_inside_reg;
    logic signed [P_W-1:0] j_pressure_reg;
    logic signed [P_W-1:0] pr;

    always_comb
    begin
        if (!i_inside_reg)
            pr = '0;
        else if (!i_neg_reg)
            pr = (i_pm_reg > POS_MAX) ? P_W'(POS_MAX) : P_W'(i_pm_reg);
        else
            pr = (i_pm_reg >= NEG_MAG) ? P_W'(NEG_MAG) : -P_W'(i_pm_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_valid_reg <= 1'b0;
        else if (en)
            j_valid_reg <= i_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_inside_reg   <= i_inside_reg;
            j_pressure_reg <= pr;
        end
    end

    // ------------------------------------------------------------------
    // output register and skid register
    // ------------------------------------------------------------------
    logic                  out_valid_reg, out_inside_reg, skid_inside_reg;
    logic signed [P_W-1:0] out_pressure_reg, skid_pressure_reg;
    logic                  out_take;

    assign out_take = out_valid_reg && result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_take)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
        end
        else if (out_take || !out_valid_reg)
            out_valid_reg <= j_valid_reg;
        else if (j_valid_reg)
            skid_full_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_take)
            begin
                out_pressure_reg <= skid_pressure_reg;
                out_inside_reg   <= skid_inside_reg;
            end
        end
        else if (out_take || !out_valid_reg)
        begin
            out_pressure_reg <= j_pressure_reg;
            out_inside_reg   <= j_inside_reg;
        end
        else
        begin
            skid_pressure_reg <= j_pressure_reg;
            skid_inside_reg   <= j_inside_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.pressure   = out_pressure_reg;
    assign result.inside_res = out_inside_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !result.ready |=> skid_full_reg)
        else $error("skid result dropped without a transfer");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_inside_reg |-> out_pressure_reg == '0)
        else $error("nonzero pressure outside the radius");

    a_g_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid_reg |-> h_g_reg <= S_W'(S_ONE))
        else $error("falloff factor above one");

endmodule

/* tb/sv/rpbf_bump_checker.sv */
// checker: watches both channels and the register port, predicts the pressure and compares
`timescale 1ns / 1ps
module rpbf_bump_checker
    import rpbf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rpbf_point_if             point,
    rpbf_result_if            result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output int                fail_count,
    output int                pending_count,
    output int                result_count,
    output int                inside_count
);

    typedef struct packed {
        logic signed [31:0] pressure;
        logic               inside_res;
    } bump_t;

    bump_t           expected_bumps[$];
    logic [31:0]     cx, cy, peak;
    logic [30:0]     rad, spx, spy;
    logic [15:0]     coff, roff;

    function automatic longint unsigned absval(longint a);
        return a < 0 ? longint'(0) - a : a;
    endfunction

    // q.30 product, magnitude truncated
    function automatic longint scale_q30(longint a, longint unsigned s);
        longint unsigned m, p;
        begin
            m = absval(a);
            p = ((m >> 15) * s + (((m & 64'h7fff) * s) >> 15)) >> 15;
            return a < 0 ? -longint'(p) : longint'(p);
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        begin
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        end
    endfunction

    function automatic bump_t predict_pressure(logic [11:0] col, logic [11:0] rw);
        bump_t           o;
        longint          dx, dy, v, g, pk, pr;
        longint unsigned ax, ay, d2, r, s, s2, s3, s6, pm, rr;
        begin
            o = '0;
            rr = rad;
            dx = longint'(spx) * (longint'(col) + longint'(coff)) - longint'(signed'(cx));
            dy = longint'(spy) * (longint'(rw) + longint'(roff)) - longint'(signed'(cy));
            ax = absval(dx);
            ay = absval(dy);
            if (ax > rr || ay > rr) return o;
            d2 = ax * ax + ay * ay;
            if (d2 > rr * rr) return o;
            r = int_sqrt(d2);
            s = rr == 0 ? 0 : (r << 30) / rr;
            if (s > 64'd1 << 30) s = 64'd1 << 30;
            v = 252 * S_ONE;
            v = -1386 * S_ONE + scale_q30(v, s);
            v = 3080 * S_ONE + scale_q30(v, s);
            v = -3465 * S_ONE + scale_q30(v, s);
            v = 1980 * S_ONE + scale_q30(v, s);
            v = -462 * S_ONE + scale_q30(v, s);
            s2 = (s * s) >> 30;
            s3 = (s2 * s) >> 30;
            s6 = (s3 * s3) >> 30;
            g = S_ONE + scale_q30(v, s6);
            if (g < 0) g = 0;
            if (g > S_ONE) g = S_ONE;
            pk = longint'(signed'(peak));
            pm = (absval(pk) * longint'(g)) >> 30;
            pr = pk < 0 ? -longint'(pm) : longint'(pm);
            if (pr > 64'sd2147483647) pr = 64'sd2147483647;
            if (pr < -64'sd2147483648) pr = -64'sd2147483648;
            o.pressure = pr[31:0];
            o.inside_res = 1'b1;
            return o;
        end
    endfunction

    task automatic report_mismatch(string what);
        begin
            $display("%0t ns: mismatch: %s", $time, what);
            fail_count = fail_count + 1;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
        inside_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        bump_t want;
        if (!rst_n)
        begin
            cx <= '0; cy <= '0; rad <= 31'd65536; peak <= '0;
            spx <= '0; spy <= '0; coff <= '0; roff <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_CENTER_X:   cx   <= pwdata;
                    REG_CENTER_Y:   cy   <= pwdata;
                    REG_RADIUS:     rad  <= pwdata[30:0];
                    REG_PEAK:       peak <= pwdata;
                    REG_SPACING_X:  spx  <= pwdata[30:0];
                    REG_SPACING_Y:  spy  <= pwdata[30:0];
                    REG_COL_OFFSET: coff <= pwdata[15:0];
                    REG_ROW_OFFSET: roff <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (point.valid && point.ready)
                expected_bumps.push_back(predict_pressure(point.column, point.row));
            if (result.valid && result.ready)
            begin
                result_count = result_count + 1;
                if (expected_bumps.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_bumps.pop_front();
                    if (want.inside_res) inside_count = inside_count + 1;
                    if (result.pressure !== want.pressure)
                        report_mismatch($sformatf("pressure %0d, expected %0d",
                            result.pressure, want.pressure));
                    if (result.inside_res !== want.inside_res)
                        report_mismatch($sformatf("inside_res %0b, expected %0b",
                            result.inside_res, want.inside_res));
                end
            end
            pending_count = expected_bumps.size();
        end
    end

endmodule

/* tb/sv/tb_radial_pressure_bump_field_unit.sv */
// testbench top: stimulus, register programming and verdict for the pressure bump unit
`timescale 1ns / 1ps
module tb_radial_pressure_bump_field_unit;
    import rpbf_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_W-1:0]  pwdata, prdata;
    int                fail_count, pending_count, result_count, inside_count;
    int                idle_pct;   // idling chance per side, zero during the quiet stretch
    int                sent_points;

    rpbf_point_if  point ();
    rpbf_result_if result ();

    radial_pressure_bump_field_unit u_top (
        .clk(clk), .rst_n(rst_n), .point(point.sink), .result(result.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rpbf_bump_checker u_checker (
        .clk(clk), .rst_n(rst_n), .point(point), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
        .pending_count(pending_count), .result_count(result_count),
        .inside_count(inside_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: random back-pressure
    always @(posedge clk)
        result.ready <= ($urandom_range(99) >= idle_pct);

    // setup then access cycle, register written at the access edge
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        begin
            psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
            paddr <= ADDR_W'(idx) << 2; pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        end
    endtask

    // one grid point transfer, with random gaps before it
    task automatic send_point(logic [11:0] col, logic [11:0] rw);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                point.valid <= 1'b0;
                @(posedge clk);
            end
            point.valid <= 1'b1; point.column <= col; point.row <= rw;
            @(posedge clk);
            while (!point.ready) @(posedge clk);
            sent_points = sent_points + 1;
        end
    endtask

    // drop valid and wait for the pipe to empty before touching registers
    task automatic drain;
        begin
            point.valid <= 1'b0;
            @(posedge clk);
            while (pending_count != 0) @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // writes all eight field registers: centre, radius, peak, spacing and offsets
    task automatic program_field(logic [31:0] cxv, logic [31:0] cyv, logic [31:0] radv,
                                 logic [31:0] pk, logic [31:0] sx, logic [31:0] sy,
                                 logic [15:0] co, logic [15:0] ro);
        begin
            write_reg(REG_CENTER_X, cxv);   write_reg(REG_CENTER_Y, cyv);
            write_reg(REG_RADIUS, radv);    write_reg(REG_PEAK, pk);
            write_reg(REG_SPACING_X, sx);   write_reg(REG_SPACING_Y, sy);
            write_reg(REG_COL_OFFSET, co);  write_reg(REG_ROW_OFFSET, ro);
        end
    endtask

    initial
    begin
        logic [11:0] c, r;
        int          span;
        idle_pct = 34;
        sent_points = 0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        point.valid = 1'b0; point.column = '0; point.row = '0;
        result.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: spacing zero puts every point at the centre
        send_point(12'd0, 12'd0);
        send_point(12'hfff, 12'hfff);
        drain();

        // unit spacing, centre at (8,8), radius 4, full positive peak
        program_field(32'd8 << 16, 32'd8 << 16, 32'd4 << 16, 32'h7fffffff,
                      32'd1 << 16, 32'd1 << 16, 16'd0, 16'd0);
        send_point(12'd8, 12'd8);      // at the centre
        send_point(12'd12, 12'd8);     // exactly on the rim
        send_point(12'd13, 12'd8);     // just outside on the axis
        send_point(12'd11, 12'd11);    // inside the box, outside the circle
        send_point(12'd10, 12'd9);
        send_point(12'd4, 12'd8);
        send_point(12'd0, 12'hfff);
        drain();

        // zero radius and most negative peak: only the exact centre is inside
        program_field(32'd3 << 16, 32'd5 << 16, 32'd0, 32'h80000000,
                      32'd1 << 16, 32'd1 << 16, 16'd0, 16'd0);
        send_point(12'd3, 12'd5);
        send_point(12'd3, 12'd6);
        drain();

        // largest spacing, radius and offsets, centre at the extremes
        program_field(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h12345678,
                      32'h7fffffff, 32'h7fffffff, 16'hffff, 16'hffff);
        send_point(12'd0, 12'd0);
        send_point(12'hfff, 12'hfff);
        send_point(12'hfff, 12'd0);
        drain();

        // random phases: bumps placed over a small tile
        for (int ph = 0; ph < 12; ph++)
        begin
            span = $urandom_range(3, 40);
            program_field($urandom_range(0, 2 * span) << 14,
                          $urandom_range(0, 2 * span) << 14,
                          ($urandom_range(1, span) << 16) + $urandom_range(0, 65535),
                          $urandom(), $urandom_range(1 << 14, 1 << 17),
                          $urandom_range(1 << 14, 1 << 17),
                          16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
            if (ph == 5)
                write_reg(REG_RADIUS, 32'hffffffff);  // masked to the largest radius
            idle_pct = (ph == 3) ? 0 : 34;            // one stretch with no idling
            for (int k = 0; k < 120; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    c = 12'($urandom()); r = 12'($urandom());
                end
                else
                begin
                    c = 12'($urandom_range(0, 3 * span));
                    r = 12'($urandom_range(0, 3 * span));
                end
                send_point(c, r);
            end
            drain();
        end
        idle_pct = 34;

        // wait out the pipeline latency with a limit
        for (int w = 0; w < 2000 && pending_count != 0; w++) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d points, %0d results of which %0d inside the bump",
                 sent_points, result_count, inside_count);
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
